// ===== design/klwt_pkg.sv =====
// Shared types, constants and layout table functions for the keyboard layout transliterator.
package klwt_pkg;

   localparam int LEN_W      = 6;
   localparam int UNIT_W     = 16;
   localparam int CMD_DEPTH  = 2;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0] out_unit;
      logic              run_last;
   } rsp_type;

   // one flushed word (possibly empty) plus an optional trailing delimiter
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic              bank;
      logic              rus;
      logic              has_delim;
      logic [UNIT_W-1:0] delim;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic              bank;
      logic [LEN_W-1:0]  idx;
      logic [UNIT_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic              hit;
      logic [UNIT_W-1:0] unit;
   } map_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_WORD,
      BACK_DELIM
   } back_state_type;

   // Russian key to English key; miss returns the unit unchanged
   function automatic map_type map_r2e(input logic [UNIT_W-1:0] u);
      map_type m;
      m.hit  = 1'b1;
      m.unit = u;
      unique case (u)
         16'h0439: m.unit = 16'h0071;
         16'h0446: m.unit = 16'h0077;
         16'h0443: m.unit = 16'h0065;
         16'h043A: m.unit = 16'h0072;
         16'h0435: m.unit = 16'h0074;
         16'h043D: m.unit = 16'h0079;
         16'h0433: m.unit = 16'h0075;
         16'h0448: m.unit = 16'h0069;
         16'h0449: m.unit = 16'h006F;
         16'h0437: m.unit = 16'h0070;
         16'h0445: m.unit = 16'h005B;
         16'h044A: m.unit = 16'h005D;
         16'h0444: m.unit = 16'h0061;
         16'h044B: m.unit = 16'h0073;
         16'h0432: m.unit = 16'h0064;
         16'h0430: m.unit = 16'h0066;
         16'h043F: m.unit = 16'h0067;
         16'h0440: m.unit = 16'h0068;
         16'h043E: m.unit = 16'h006A;
         16'h043B: m.unit = 16'h006B;
         16'h0434: m.unit = 16'h006C;
         16'h0436: m.unit = 16'h003B;
         16'h044D: m.unit = 16'h0027;
         16'h044F: m.unit = 16'h007A;
         16'h0447: m.unit = 16'h0078;
         16'h0441: m.unit = 16'h0063;
         16'h043C: m.unit = 16'h0076;
         16'h0438: m.unit = 16'h0062;
         16'h0442: m.unit = 16'h006E;
         16'h044C: m.unit = 16'h006D;
         16'h0431: m.unit = 16'h002C;
         16'h044E: m.unit = 16'h002E;
         16'h0451: m.unit = 16'h0060;
         16'h0419: m.unit = 16'h0051;
         16'h0426: m.unit = 16'h0057;
         16'h0423: m.unit = 16'h0045;
         16'h041A: m.unit = 16'h0052;
         16'h0415: m.unit = 16'h0054;
         16'h041D: m.unit = 16'h0059;
         16'h0413: m.unit = 16'h0055;
         16'h0428: m.unit = 16'h0049;
         16'h0429: m.unit = 16'h004F;
         16'h0417: m.unit = 16'h0050;
         16'h0425: m.unit = 16'h007B;
         16'h042A: m.unit = 16'h007D;
         16'h0424: m.unit = 16'h0041;
         16'h042B: m.unit = 16'h0053;
         16'h0412: m.unit = 16'h0044;
         16'h0410: m.unit = 16'h0046;
         16'h041F: m.unit = 16'h0047;
         16'h0420: m.unit = 16'h0048;
         16'h041E: m.unit = 16'h004A;
         16'h041B: m.unit = 16'h004B;
         16'h0414: m.unit = 16'h004C;
         16'h0416: m.unit = 16'h003A;
         16'h042D: m.unit = 16'h0022;
         16'h042F: m.unit = 16'h005A;
         16'h0427: m.unit = 16'h0058;
         16'h0421: m.unit = 16'h0043;
         16'h041C: m.unit = 16'h0056;
         16'h0418: m.unit = 16'h0042;
         16'h0422: m.unit = 16'h004E;
         16'h042C: m.unit = 16'h004D;
         16'h0411: m.unit = 16'h003C;
         16'h042E: m.unit = 16'h003E;
         16'h0401: m.unit = 16'h007E;
         16'h0022: m.unit = 16'h0040;
         16'h2116: m.unit = 16'h0023;
         16'h003B: m.unit = 16'h0024;
         16'h003A: m.unit = 16'h005E;
         16'h003F: m.unit = 16'h0026;
         16'h002E: m.unit = 16'h002F;
         16'h002C: m.unit = 16'h003F;
         16'h002F: m.unit = 16'h007C;
         default:  m.hit  = 1'b0;
      endcase
      return m;
   endfunction

   // English key to Russian key; miss returns the unit unchanged
   function automatic map_type map_e2r(input logic [UNIT_W-1:0] u);
      map_type m;
      m.hit  = 1'b1;
      m.unit = u;
      unique case (u)
         16'h0071: m.unit = 16'h0439;
         16'h0077: m.unit = 16'h0446;
         16'h0065: m.unit = 16'h0443;
         16'h0072: m.unit = 16'h043A;
         16'h0074: m.unit = 16'h0435;
         16'h0079: m.unit = 16'h043D;
         16'h0075: m.unit = 16'h0433;
         16'h0069: m.unit = 16'h0448;
         16'h006F: m.unit = 16'h0449;
         16'h0070: m.unit = 16'h0437;
         16'h005B: m.unit = 16'h0445;
         16'h005D: m.unit = 16'h044A;
         16'h0061: m.unit = 16'h0444;
         16'h0073: m.unit = 16'h044B;
         16'h0064: m.unit = 16'h0432;
         16'h0066: m.unit = 16'h0430;
         16'h0067: m.unit = 16'h043F;
         16'h0068: m.unit = 16'h0440;
         16'h006A: m.unit = 16'h043E;
         16'h006B: m.unit = 16'h043B;
         16'h006C: m.unit = 16'h0434;
         16'h003B: m.unit = 16'h0436;
         16'h0027: m.unit = 16'h044D;
         16'h007A: m.unit = 16'h044F;
         16'h0078: m.unit = 16'h0447;
         16'h0063: m.unit = 16'h0441;
         16'h0076: m.unit = 16'h043C;
         16'h0062: m.unit = 16'h0438;
         16'h006E: m.unit = 16'h0442;
         16'h006D: m.unit = 16'h044C;
         16'h002C: m.unit = 16'h0431;
         16'h002E: m.unit = 16'h044E;
         16'h0060: m.unit = 16'h0451;
         16'h0051: m.unit = 16'h0419;
         16'h0057: m.unit = 16'h0426;
         16'h0045: m.unit = 16'h0423;
         16'h0052: m.unit = 16'h041A;
         16'h0054: m.unit = 16'h0415;
         16'h0059: m.unit = 16'h041D;
         16'h0055: m.unit = 16'h0413;
         16'h0049: m.unit = 16'h0428;
         16'h004F: m.unit = 16'h0429;
         16'h0050: m.unit = 16'h0417;
         16'h007B: m.unit = 16'h0425;
         16'h007D: m.unit = 16'h042A;
         16'h0041: m.unit = 16'h0424;
         16'h0053: m.unit = 16'h042B;
         16'h0044: m.unit = 16'h0412;
         16'h0046: m.unit = 16'h0410;
         16'h0047: m.unit = 16'h041F;
         16'h0048: m.unit = 16'h0420;
         16'h004A: m.unit = 16'h041E;
         16'h004B: m.unit = 16'h041B;
         16'h004C: m.unit = 16'h0414;
         16'h003A: m.unit = 16'h0416;
         16'h0022: m.unit = 16'h042D;
         16'h005A: m.unit = 16'h042F;
         16'h0058: m.unit = 16'h0427;
         16'h0043: m.unit = 16'h0421;
         16'h0056: m.unit = 16'h041C;
         16'h0042: m.unit = 16'h0418;
         16'h004E: m.unit = 16'h0422;
         16'h004D: m.unit = 16'h042C;
         16'h003C: m.unit = 16'h0411;
         16'h003E: m.unit = 16'h042E;
         16'h007E: m.unit = 16'h0401;
         16'h0040: m.unit = 16'h0022;
         16'h0023: m.unit = 16'h2116;
         16'h0024: m.unit = 16'h003B;
         16'h005E: m.unit = 16'h003A;
         16'h0026: m.unit = 16'h003F;
         16'h002F: m.unit = 16'h002E;
         16'h003F: m.unit = 16'h002C;
         16'h007C: m.unit = 16'h002F;
         default:  m.hit  = 1'b0;
      endcase
      return m;
   endfunction

endpackage

// ===== design/keyboard_layout_word_transliterator.sv =====
// Keyboard layout word transliterator top level.
// Takes one UTF-16 code unit per word on the req_ queue and returns
// transliterated code units on the rsp_ queue. Units that are keys of the
// Russian or English layout set collect into a word of up to WORD_DEPTH
// units; a non-key unit, end_of_text or a full word flushes it through the
// Russian-to-English map when Russian keys strictly outnumber English keys,
// and through the English-to-Russian map otherwise, followed by the
// delimiter when a non-key unit flushed it. run_last marks the final result of each flush command.
// The front end takes a unit per cycle; it holds full while the two-entry
// command queue is full or the store bank it would write is still being
// read out. The back end loads each flush command while idle, then
// emits one result per cycle while the result queue has room, through a
// registered store read and the map stage. No clearing pass runs after
// reset.
module keyboard_layout_word_transliterator import klwt_pkg::*; #(
   parameter int WORD_DEPTH = 63
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_payload,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_payload
);

   logic                 cmd_push, cmd_pop, cmd_full, cmd_empty;
   cmd_type              cmd_wdata, cmd_rdata;
   logic [CMD_CNT_W-1:0] cmd_count;
   store_wr_type         store_wr;
   release_type          bank_release;
   logic                 out_push, out_full;
   rsp_type              out_data;
   logic [OUT_CNT_W-1:0] out_count;

   klwt_front #(
      .WORD_DEPTH (WORD_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (push),
      .req_payload  (req_payload),
      .req_full     (full),
      .cmd_full     (cmd_full),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_wdata),
      .store_wr     (store_wr),
      .bank_release (bank_release)
   );

   klwt_fifo #(
      .T     (cmd_type),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .full      (cmd_full),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   klwt_back #(
      .WORD_DEPTH (WORD_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .store_wr     (store_wr),
      .cmd_empty    (cmd_empty || (cmd_count == '0)),
      .cmd_data     (cmd_rdata),
      .cmd_pop      (cmd_pop),
      .bank_release (bank_release),
      .out_count    (out_count),
      .out_push     (out_push),
      .out_data     (out_data)
   );

   klwt_fifo #(
      .T     (rsp_type),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push && !out_full),
      .push_data (out_data),
      .pop       (pop),
      .pop_data  (rsp_payload),
      .full      (out_full),
      .empty     (empty),
      .count     (out_count)
   );

endmodule

// ===== design/klwt_fifo.sv =====
// Small synchronous first-in first-out queue of any packed type.
module klwt_fifo import klwt_pkg::*; #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  T                             push_data,
   input  logic                         pop,
   output T                             pop_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   T                 slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/klwt_front.sv =====
// Front end: classifies each code unit, builds words in a two-bank store, queues flush commands.
module klwt_front import klwt_pkg::*; #(
   parameter int WORD_DEPTH = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_type      req_payload,
   output logic         req_full,
   input  logic         cmd_full,
   output logic         cmd_push,
   output cmd_type      cmd_data,
   output store_wr_type store_wr,
   input  release_type  bank_release
);

   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] rus_count_ff, rus_count_in;
   logic [LEN_W-1:0] eng_count_ff, eng_count_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   map_type          cls_rus, cls_eng;
   logic             accept, member, flush;
   logic [LEN_W-1:0] len_next, rus_next, eng_next;

   // a bank being read out by the back end cannot take a new word
   assign req_full = cmd_full || busy_ff[bank_ff];
   assign accept   = req_push && !req_full;

   always_comb begin
      cls_rus  = map_r2e(req_payload.code_unit);
      cls_eng  = map_e2r(req_payload.code_unit);
      member   = cls_rus.hit || cls_eng.hit;
      len_next = length_ff + LEN_W'(1);
      rus_next = rus_count_ff + LEN_W'(cls_rus.hit);
      eng_next = eng_count_ff + LEN_W'(cls_eng.hit);
      flush    = req_payload.end_of_text || (len_next == LEN_W'(WORD_DEPTH));

      length_in    = length_ff;
      rus_count_in = rus_count_ff;
      eng_count_in = eng_count_ff;
      bank_in      = bank_ff;
      busy_in      = busy_ff;
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end

      store_wr.en   = accept && member;
      store_wr.bank = bank_ff;
      store_wr.idx  = length_ff;
      store_wr.data = req_payload.code_unit;

      cmd_push           = 1'b0;
      cmd_data.len       = length_ff;
      cmd_data.bank      = bank_ff;
      cmd_data.rus       = rus_count_ff > eng_count_ff;
      cmd_data.has_delim = 1'b1;
      cmd_data.delim     = req_payload.code_unit;

      if (accept) begin
         if (member) begin
            length_in    = len_next;
            rus_count_in = rus_next;
            eng_count_in = eng_next;
            if (flush) begin
               cmd_push           = 1'b1;
               cmd_data.len       = len_next;
               cmd_data.rus       = rus_next > eng_next;
               cmd_data.has_delim = 1'b0;
               busy_in[bank_ff]   = 1'b1;
               bank_in            = !bank_ff;
               length_in          = '0;
               rus_count_in       = '0;
               eng_count_in       = '0;
            end
         end else begin
            // pending word, if any, then the delimiter
            cmd_push     = 1'b1;
            length_in    = '0;
            rus_count_in = '0;
            eng_count_in = '0;
            if (length_ff != '0) begin
               busy_in[bank_ff] = 1'b1;
               bank_in          = !bank_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rus_count_ff <= '0;
         eng_count_ff <= '0;
         bank_ff      <= 1'b0;
         busy_ff      <= '0;
      end else begin
         length_ff    <= length_in;
         rus_count_ff <= rus_count_in;
         eng_count_ff <= eng_count_in;
         bank_ff      <= bank_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

// ===== design/klwt_back.sv =====
// Back end: word store, read-out sequencer and mapping stage feeding the result queue.
module klwt_back import klwt_pkg::*; #(
   parameter int WORD_DEPTH = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  store_wr_type         store_wr,
   input  logic                 cmd_empty,
   input  cmd_type              cmd_data,
   output logic                 cmd_pop,
   output release_type          bank_release,
   input  logic [OUT_CNT_W-1:0] out_count,
   output logic                 out_push,
   output rsp_type              out_data
);

   localparam int IDX_W = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
   localparam int MEM_N = 2 ** (IDX_W + 1);

   typedef struct packed {
      logic              valid;
      logic              is_delim;
      logic              rus;
      logic              last;
      logic [UNIT_W-1:0] delim;
   } rd_stage_type;

   logic [UNIT_W-1:0] store_mem [MEM_N];
   logic [UNIT_W-1:0] rd_data_ff;

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              p1_valid_ff;
   rd_stage_type      p1_ff, p1_in;

   logic              room, rd_en, last_rd;
   logic [IDX_W:0]    rd_addr;
   map_type           mapped;

   // one result in flight per issue; keep the result queue from overflowing
   assign room    = p1_valid_ff ? (out_count <= OUT_CNT_W'(OUT_DEPTH - 2))
                                : (out_count <= OUT_CNT_W'(OUT_DEPTH - 1));
   assign rd_addr = {cmd_ff.bank, idx_ff[IDX_W-1:0]};
   assign last_rd = (idx_ff == cmd_ff.len - LEN_W'(1));

   always_comb begin
      state_in           = state_ff;
      cmd_in             = cmd_ff;
      idx_in             = idx_ff;
      cmd_pop            = 1'b0;
      rd_en              = 1'b0;
      bank_release.valid = 1'b0;
      bank_release.bank  = cmd_ff.bank;
      p1_in.valid        = 1'b0;
      p1_in.is_delim     = 1'b0;
      p1_in.rus          = cmd_ff.rus;
      p1_in.last         = 1'b0;
      p1_in.delim        = cmd_ff.delim;

      unique case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               idx_in   = '0;
               state_in = (cmd_data.len != '0) ? BACK_WORD : BACK_DELIM;
            end
         end
         BACK_WORD: begin
            if (room) begin
               rd_en       = 1'b1;
               p1_in.valid = 1'b1;
               p1_in.last  = last_rd && !cmd_ff.has_delim;
               idx_in      = idx_ff + LEN_W'(1);
               if (last_rd) begin
                  bank_release.valid = 1'b1;
                  state_in = cmd_ff.has_delim ? BACK_DELIM : BACK_IDLE;
               end
            end
         end
         BACK_DELIM: begin
            if (room) begin
               p1_in.valid    = 1'b1;
               p1_in.is_delim = 1'b1;
               p1_in.last     = 1'b1;
               state_in       = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         p1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= p1_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      p1_ff  <= p1_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[{store_wr.bank, store_wr.idx[IDX_W-1:0]}] <= store_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      mapped = p1_ff.rus ? map_r2e(rd_data_ff) : map_e2r(rd_data_ff);
      out_push          = p1_valid_ff;
      out_data.out_unit = p1_ff.is_delim ? p1_ff.delim : mapped.unit;
      out_data.run_last = p1_ff.last;
   end

endmodule
